FILE: rtl/lsfc_pkg.sv
// ----------------------------------------------------------------------------
// lsfc_pkg: log-step frame codec package
// operation codes, segment constants and the segment base lookup
// ----------------------------------------------------------------------------
package lsfc_pkg;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    localparam int unsigned SEG_SHIFT   = 6;
    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned CODE_W      = 8;
    localparam int unsigned FRAMES_W    = 10;
    localparam logic [FRAMES_W-1:0] MAX_FRAMES = 10'd952;

    typedef logic [1:0] seg_t;

    // first decoded value of each segment
    function automatic logic [FRAMES_W-1:0] seg_base(input seg_t s);
        logic [FRAMES_W-1:0] b;
        case (s)
            2'd0:    b = 10'd0;
            2'd1:    b = 10'd64;
            2'd2:    b = 10'd192;
            2'd3:    b = 10'd448;
            default: b = 10'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/lsfc_conv.sv
// ----------------------------------------------------------------------------
// lsfc_conv: code conversion datapath
// encodes a frame count to the nearest code point or decodes a code
// ----------------------------------------------------------------------------
module lsfc_conv
    import lsfc_pkg::*;
(
    input  op_t                 operation,
    input  logic [VALUE_W-1:0]  value,
    output logic [CODE_W-1:0]   code,
    output logic [FRAMES_W-1:0] frames
);

    logic [FRAMES_W-1:0] clamped;
    seg_t                enc_seg;
    logic [FRAMES_W-1:0] enc_off;
    logic [FRAMES_W-1:0] enc_half;
    logic [FRAMES_W-1:0] enc_sum;
    logic [FRAMES_W-1:0] enc_q;
    logic [CODE_W:0]     enc_code;
    logic [CODE_W-1:0]   enc_result;
    seg_t                dec_seg;
    logic [5:0]          dec_idx;
    logic [FRAMES_W-1:0] dec_result;

    // encode: clamp, find segment, round to nearest point (tie goes up)
    always_comb
    begin
        clamped = (value > VALUE_W'(MAX_FRAMES)) ? MAX_FRAMES : value[FRAMES_W-1:0];
        if (clamped < seg_base(2'd1))
        begin
            enc_seg = 2'd0;
        end
        else if (clamped < seg_base(2'd2))
        begin
            enc_seg = 2'd1;
        end
        else if (clamped < seg_base(2'd3))
        begin
            enc_seg = 2'd2;
        end
        else
        begin
            enc_seg = 2'd3;
        end
        enc_off = clamped - seg_base(enc_seg);
        case (enc_seg)
            2'd1:    enc_half = 10'd1;
            2'd2:    enc_half = 10'd2;
            2'd3:    enc_half = 10'd4;
            default: enc_half = 10'd0;
        endcase
        enc_sum  = enc_off + enc_half;
        enc_q    = enc_sum >> enc_seg;
        // a carry of the offset past 63 lands on the next segment's first code
        enc_code = {1'b0, enc_seg, 6'd0} + enc_q[CODE_W:0];
        enc_result = (enc_seg == 2'd0) ? clamped[CODE_W-1:0] : enc_code[CODE_W-1:0];
    end

    // decode: base plus scaled index
    always_comb
    begin
        dec_seg    = value[7:SEG_SHIFT];
        dec_idx    = value[SEG_SHIFT-1:0];
        dec_result = seg_base(dec_seg) + (FRAMES_W'(dec_idx) << dec_seg);
    end

    always_comb
    begin
        case (operation)
            OP_ENCODE:
            begin
                code   = enc_result;
                frames = '0;
            end
            OP_DECODE:
            begin
                code   = '0;
                frames = dec_result;
            end
            default:
            begin
                code   = '0;
                frames = '0;
            end
        endcase
    end

endmodule

FILE: rtl/log_step_frame_codec_top.sv
// ----------------------------------------------------------------------------
// log_step_frame_codec_top: log-step frame codec
// stateless lossy converter between frame counts (16-bit in, 10-bit out) and 8-bit codes
// ----------------------------------------------------------------------------
//
// channel   direction  handshake         payload
// -------   ---------  ----------------  ------------------------
// command   in         start & !busy     operation, value
// result    out        done (one cycle)  code, frames
//
// one transfer per cycle, sustained; busy is never raised
// the result strobe follows the command transfer through the input register,
//   the conversion logic and the result register
// reset clears the valid flags only; payload registers are not reset
// the receiver takes each result in the cycle it is shown, no stall path
//
module log_step_frame_codec_top
    import lsfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                operation,
    input  logic [VALUE_W-1:0]  value,
    output logic                done,
    output logic [CODE_W-1:0]   code,
    output logic [FRAMES_W-1:0] frames
);

    // input stage
    logic                in_valid_reg;
    op_t                 op_reg;
    logic [VALUE_W-1:0]  value_reg;

    // result stage
    logic                done_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [FRAMES_W-1:0] frames_reg;

    logic [CODE_W-1:0]   code_next;
    logic [FRAMES_W-1:0] frames_next;
    logic                accept;

    // the pipeline never backs up, so commands are always taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(operation);
            value_reg <= value;
        end
        if (in_valid_reg)
        begin
            code_reg   <= code_next;
            frames_reg <= frames_next;
        end
    end

    // conversion between the two register stages
    lsfc_conv u_conv (
        .operation (op_reg),
        .value     (value_reg),
        .code      (code_next),
        .frames    (frames_next)
    );

    assign done   = done_reg;
    assign code   = code_reg;
    assign frames = frames_reg;

    // every command transfer yields a result after the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result strobe missing after command transfer");

    // no result without a command transfer ahead of the input and result registers
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result strobe without a command");

    // only one of the two result fields carries data
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (code == '0) || (frames == '0))
        else $error("both code and frames nonzero");

    // decoded counts stay within range
    a_frames_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> frames <= MAX_FRAMES)
        else $error("decoded frame count out of range");

endmodule
